[src/edfts_pkg.sv]
// ----------------------------------------------------------------------------
// edfts_pkg: shared types and constants
// Widths, choice codes and the beat records that pass between the cells of
// the tick scheduler.
// ----------------------------------------------------------------------------
package edfts_pkg;

    localparam int MAX_TASKS  = 8;
    localparam int TIME_BITS  = 16;
    localparam int SLACK_BITS = TIME_BITS + 2;
    localparam int IDX_BITS   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_BITS   = 4;
    localparam int CODE_BITS  = $clog2(MAX_TASKS + 2);

    localparam logic [CODE_BITS-1:0] CODE_IDLE = CODE_BITS'(MAX_TASKS);
    localparam logic [CODE_BITS-1:0] CODE_NONE = CODE_BITS'(MAX_TASKS + 1);

    localparam logic [SLACK_BITS-1:0] SLACK_MIN = {1'b1, {(SLACK_BITS-1){1'b0}}};

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [IDX_BITS-1:0]  idx_t;

    // search beat handed from cell to cell
    typedef struct packed {
        logic                          valid;
        logic                          found;
        idx_t                          pick;
        logic signed [SLACK_BITS-1:0]  best;
    } token_t;

    // end-of-tick update broadcast to all cells
    typedef struct packed {
        logic valid;
        logic found;
        idx_t pick;
    } commit_t;

endpackage

[src/edfts_cell.sv]
// ----------------------------------------------------------------------------
// edfts_cell: one task slot
// Holds one task's tables and running state, releases the task when the
// search beat passes and its countdown has run out, folds it into the
// least-slack search and hands the beat to the next cell.
// ----------------------------------------------------------------------------
module edfts_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  edfts_pkg::idx_t    cell_id,
    input  logic               active,
    input  logic               load_en,
    input  edfts_pkg::time_t   capacity,
    input  edfts_pkg::time_t   rel_deadline,
    input  edfts_pkg::time_t   task_period,
    input  edfts_pkg::token_t  tok_in,
    input  edfts_pkg::commit_t commit,
    output edfts_pkg::token_t  tok_out
);
    import edfts_pkg::*;

    time_t                        cap_reg;
    time_t                        deadline_reg;
    time_t                        period_reg;
    time_t                        pend_reg;
    time_t                        pend_next;
    logic signed [SLACK_BITS-1:0] slack_reg;
    logic signed [SLACK_BITS-1:0] slack_next;
    time_t                        cnt_reg;
    time_t                        cnt_next;
    token_t                       tok_reg;
    token_t                       tok_next;

    logic                         release_now;
    logic [TIME_BITS:0]           pend_sum;
    time_t                        pend_rel;
    logic signed [SLACK_BITS-1:0] slack_rel;
    logic                         take;

    always_comb
    begin
        release_now = tok_in.valid && active && (cnt_reg == '0);
        pend_sum    = {1'b0, pend_reg} + {1'b0, cap_reg};
        if (release_now)
        begin
            pend_rel  = pend_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : pend_sum[TIME_BITS-1:0];
            slack_rel = $signed({{(SLACK_BITS-TIME_BITS){1'b0}}, deadline_reg});
        end
        else
        begin
            pend_rel  = pend_reg;
            slack_rel = slack_reg;
        end
        take = active && (pend_rel != '0) && (!tok_in.found || (slack_rel < tok_in.best));

        tok_next       = tok_in;
        if (take)
        begin
            tok_next.found = 1'b1;
            tok_next.pick  = cell_id;
            tok_next.best  = slack_rel;
        end

        pend_next  = pend_reg;
        slack_next = slack_reg;
        cnt_next   = cnt_reg;
        if (load_en)
        begin
            pend_next = '0;
            cnt_next  = '0;
        end
        else if (release_now)
        begin
            pend_next  = pend_rel;
            slack_next = slack_rel;
            cnt_next   = period_reg;
        end
        else if (commit.valid && active)
        begin
            if (commit.found && (commit.pick == cell_id))
                pend_next = pend_reg - TIME_BITS'(1);
            if (slack_reg != $signed(SLACK_MIN))
                slack_next = slack_reg - SLACK_BITS'(1);
            if (cnt_reg != '0)
                cnt_next = cnt_reg - TIME_BITS'(1);
        end
    end

    // task tables: undefined until loaded
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            cap_reg      <= capacity;
            deadline_reg <= rel_deadline;
            period_reg   <= task_period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            slack_reg <= '0;
            cnt_reg   <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            pend_reg  <= pend_next;
            slack_reg <= slack_next;
            cnt_reg   <= cnt_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[src/edf_tick_scheduler_top.sv]
// ----------------------------------------------------------------------------
// edf_tick_scheduler_top: periodic earliest-deadline-first tick scheduler
// A load beat gives no result. A tick beat runs a search beat down the row
// of task cells, one cell per cycle, then commits. done pulses once the
// commit is registered; busy holds from start until then, so a new start
// waits for busy to drop. The result cannot be stalled.
// Reset clears pending work, slack, countdowns, the last choice and the
// active count; task tables hold garbage until loaded.
// ----------------------------------------------------------------------------
module edf_tick_scheduler_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      req_type,
    input  logic [2:0]                task_index,
    input  logic [15:0]               capacity,
    input  logic [15:0]               rel_deadline,
    input  logic [15:0]               task_period,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [3:0]                cfg_active_tasks,
    output logic                      done,
    output logic [2:0]                running_task,
    output logic                      cpu_idle,
    output logic                      switched
);
    import edfts_pkg::*;

    logic [CNT_BITS-1:0]  active_reg;
    logic [CNT_BITS-1:0]  live_count;
    logic [MAX_TASKS-1:0] active_vec;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic [2:0]           run_reg;
    logic [2:0]           run_next;
    logic                 idle_reg;
    logic                 sw_reg;
    logic                 sw_next;
    logic [CODE_BITS-1:0] prev_reg;
    logic [CODE_BITS-1:0] prev_next;
    logic [CODE_BITS-1:0] code;

    logic                 accept;
    logic                 load_accept;
    logic                 tick_accept;
    token_t               tok_chain [MAX_TASKS+1];
    commit_t              commit;

    assign accept      = start && !busy_reg;
    assign load_accept = accept && (req_type == REQ_LOAD);
    assign tick_accept = accept && (req_type == REQ_TICK);
    assign cfg_ready   = 1'b1;

    assign live_count = (active_reg > CNT_BITS'(MAX_TASKS)) ? CNT_BITS'(MAX_TASKS) : active_reg;

    always_comb
    begin
        tok_chain[0]       = '0;
        tok_chain[0].valid = tick_accept;
    end

    assign commit.valid = tok_chain[MAX_TASKS].valid;
    assign commit.found = tok_chain[MAX_TASKS].found;
    assign commit.pick  = tok_chain[MAX_TASKS].pick;

    genvar k;
    generate
        for (k = 0; k < MAX_TASKS; k++)
        begin : g_cell
            assign active_vec[k] = (CNT_BITS'(k) < live_count);

            edfts_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .cell_id      (IDX_BITS'(k)),
                .active       (active_vec[k]),
                .load_en      (load_accept && (task_index == 3'(k))),
                .capacity     (capacity),
                .rel_deadline (rel_deadline),
                .task_period  (task_period),
                .tok_in       (tok_chain[k]),
                .commit       (commit),
                .tok_out      (tok_chain[k+1])
            );
        end
    endgenerate

    always_comb
    begin
        code      = commit.found ? CODE_BITS'(commit.pick) : CODE_IDLE;
        run_next  = commit.found ? 3'(commit.pick) : 3'd0;
        sw_next   = (code != prev_reg);
        prev_next = commit.valid ? code : prev_reg;
        if (tick_accept)
            busy_next = 1'b1;
        else if (commit.valid)
            busy_next = 1'b0;
        else
            busy_next = busy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            prev_reg   <= CODE_NONE;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                active_reg <= cfg_active_tasks;
            busy_reg <= busy_next;
            done_reg <= commit.valid;
            prev_reg <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit.valid)
        begin
            run_reg  <= run_next;
            idle_reg <= !commit.found;
            sw_reg   <= sw_next;
        end
    end

    assign busy         = busy_reg;
    assign done         = done_reg;
    assign running_task = run_reg;
    assign cpu_idle     = idle_reg;
    assign switched     = sw_reg;

endmodule
